// ===== rtl/cpt_pkg.sv =====
package cpt_pkg;

  localparam int ADC_W = 10;
  localparam int CNT_W = 4;
  localparam int SLOT_W = 3;
  localparam int CFG_IDX_W = 3;
  localparam int FIFO_DEPTH = 4;

  localparam logic [ADC_W-1:0] ADC_SAT = 10'd1023;
  localparam logic [CNT_W-1:0] CNT_MAX = 4'd15;

  localparam logic [ADC_W-1:0] THRESHOLD_RST = 10'd70;
  localparam logic [CNT_W-1:0] MAX_BAD_PEAK_RST = 4'd4;
  localparam logic [CNT_W-1:0] MAX_BAD_CENTRAL_RST = 4'd4;
  localparam logic [CNT_W-1:0] MAX_BAD_LATE_RST = 4'd4;
  localparam logic [CNT_W-1:0] MIN_GOOD_LATE_RST = 4'd2;
  localparam logic [CNT_W-1:0] MAX_GOOD_CENTRAL_RST = 4'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD,
    CFG_MAX_BAD_PEAK,
    CFG_MAX_BAD_CENTRAL,
    CFG_MAX_BAD_LATE,
    CFG_MIN_GOOD_LATE,
    CFG_MAX_GOOD_CENTRAL
  } cfg_idx_t;

  typedef enum logic [2:0] {
    CAT_QUIET,
    CAT_SATURATED,
    CAT_BAD_PLACE,
    CAT_GOOD_CENTRAL,
    CAT_BAD_CENTRAL,
    CAT_GOOD_LATE,
    CAT_BAD_LATE
  } category_t;

  typedef enum logic [2:0] {
    REJ_NONE,
    REJ_BAD_PLACE,
    REJ_BAD_CENTRAL,
    REJ_BAD_LATE,
    REJ_FEW_GOOD_LATE,
    REJ_MANY_GOOD_CENTRAL,
    REJ_NO_EM
  } reject_t;

  typedef struct packed {
    logic [CNT_W-1:0] max_bad_peak;
    logic [CNT_W-1:0] max_bad_central;
    logic [CNT_W-1:0] max_bad_late;
    logic [CNT_W-1:0] min_good_late;
    logic [CNT_W-1:0] max_good_central;
  } limits_t;

  // classified tower, front to back
  typedef struct packed {
    category_t         category;
    logic [SLOT_W-1:0] peak_slot;
    logic              em_active;
    logic              last;
  } cls_t;

endpackage

// ===== rtl/cpt_front.sv =====
module cpt_front import cpt_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic [ADC_W-1:0] threshold,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [ADC_W-1:0] sample_0,
  input  logic [ADC_W-1:0] sample_1,
  input  logic [ADC_W-1:0] sample_2,
  input  logic [ADC_W-1:0] sample_3,
  input  logic [ADC_W-1:0] sample_4,
  input  logic             is_hadronic,
  input  logic             last_of_event,
  output logic             cls_valid,
  input  logic             cls_ready,
  output cls_t             cls
);

  logic             full;
  logic [ADC_W-1:0] smp [5];
  logic             hadronic;
  logic             last;

  logic [ADC_W-1:0]  peak;
  logic [SLOT_W-1:0] slot;
  logic [ADC_W-1:0]  a, b, c;
  logic              good;

  logic signed [15:0] sa, sb, sc;
  logic signed [15:0] lhs1, rhs1, lhs3, rhs3;

  assign in_ready  = !full || cls_ready;
  assign cls_valid = full;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (in_ready) begin
      full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      smp[0]   <= sample_0;
      smp[1]   <= sample_1;
      smp[2]   <= sample_2;
      smp[3]   <= sample_3;
      smp[4]   <= sample_4;
      hadronic <= is_hadronic;
      last     <= last_of_event;
    end
  end

  // first maximum wins ties
  always_comb begin
    peak = smp[0];
    slot = '0;
    for (int i = 1; i < 5; i++) begin
      if (smp[i] > peak) begin
        peak = smp[i];
        slot = SLOT_W'(i);
      end
    end
  end

  assign a = (slot == 3'd2) ? smp[1] : smp[2];
  assign b = (slot == 3'd2) ? smp[2] : smp[3];
  assign c = (slot == 3'd2) ? smp[3] : smp[4];

  assign sa = signed'({6'b0, a});
  assign sb = signed'({6'b0, b});
  assign sc = signed'({6'b0, c});

  assign lhs1 = 16'sd5 * (sc - sa);
  assign rhs1 = 16'sd3 * ((sb <<< 1) - sa - sc);
  assign lhs3 = 16'sd5 * (sa + sc - 16'sd64);
  assign rhs3 = 16'sd8 * (sb - 16'sd32);

  assign good = (sc >= sa) && (lhs1 <= rhs1) &&
                ((sb - 16'sd32) <= (sa + sc - 16'sd64)) && (lhs3 <= rhs3);

  always_comb begin
    cls.peak_slot = slot;
    cls.last      = last;
    cls.em_active = !hadronic && (peak >= threshold);
    if (peak < threshold) begin
      cls.category = CAT_QUIET;
    end else if (peak == ADC_SAT) begin
      cls.category = CAT_SATURATED;
    end else if (slot == 3'd2) begin
      cls.category = good ? CAT_GOOD_CENTRAL : CAT_BAD_CENTRAL;
    end else if (slot == 3'd3) begin
      cls.category = good ? CAT_GOOD_LATE : CAT_BAD_LATE;
    end else begin
      cls.category = CAT_BAD_PLACE;
    end
  end

endmodule

// ===== rtl/cpt_queue.sv =====
module cpt_queue import cpt_pkg::*; #(
  parameter int Depth = FIFO_DEPTH
) (
  input  logic clk,
  input  logic rst,
  input  logic wr_valid,
  output logic wr_ready,
  input  cls_t wr_data,
  output logic rd_valid,
  input  logic rd_ready,
  output cls_t rd_data
);

  localparam int PW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW = $clog2(Depth + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(Depth - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(Depth);

  cls_t          mem [Depth];
  logic [PW-1:0] wptr, rptr;
  logic [CW-1:0] count;
  logic          push, pop;

  assign wr_ready = (count != FULL_CNT);
  assign rd_valid = (count != '0);
  assign rd_data  = mem[rptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == LAST_PTR) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == LAST_PTR) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/cpt_back.sv =====
module cpt_back import cpt_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  limits_t           limits,
  input  logic              cls_valid,
  output logic              cls_ready,
  input  cls_t              cls,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [2:0]        category,
  output logic [SLOT_W-1:0] peak_slot,
  output logic              event_done,
  output logic              event_pass,
  output logic [2:0]        reject_stage
);

  logic [CNT_W-1:0] bad_place_count, bad_central_count, bad_late_count;
  logic [CNT_W-1:0] good_late_count, good_central_count;
  logic             em_seen;

  logic [CNT_W-1:0] bad_place_next, bad_central_next, bad_late_next;
  logic [CNT_W-1:0] good_late_next, good_central_next;
  logic             em_seen_next;
  reject_t          stage;
  logic             pop;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v, input logic en);
    sat_inc = (en && v != CNT_MAX) ? v + 1'b1 : v;
  endfunction

  assign cls_ready = !out_valid || out_ready;
  assign pop       = cls_valid && cls_ready;

  always_comb begin
    bad_place_next    = sat_inc(bad_place_count, cls.category == CAT_BAD_PLACE);
    bad_central_next  = sat_inc(bad_central_count, cls.category == CAT_BAD_CENTRAL);
    bad_late_next     = sat_inc(bad_late_count, cls.category == CAT_BAD_LATE);
    good_late_next    = sat_inc(good_late_count, cls.category == CAT_GOOD_LATE);
    good_central_next = sat_inc(good_central_count, cls.category == CAT_GOOD_CENTRAL);
    em_seen_next      = em_seen || cls.em_active;
  end

  // event cuts, first failure reported
  always_comb begin
    if (bad_place_next > limits.max_bad_peak) begin
      stage = REJ_BAD_PLACE;
    end else if (bad_central_next > limits.max_bad_central) begin
      stage = REJ_BAD_CENTRAL;
    end else if (bad_late_next > limits.max_bad_late) begin
      stage = REJ_BAD_LATE;
    end else if (good_late_next < limits.min_good_late) begin
      stage = REJ_FEW_GOOD_LATE;
    end else if (good_central_next > limits.max_good_central) begin
      stage = REJ_MANY_GOOD_CENTRAL;
    end else if (!em_seen_next) begin
      stage = REJ_NO_EM;
    end else begin
      stage = REJ_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bad_place_count    <= '0;
      bad_central_count  <= '0;
      bad_late_count     <= '0;
      good_late_count    <= '0;
      good_central_count <= '0;
      em_seen            <= 1'b0;
      out_valid          <= 1'b0;
    end else begin
      if (cls_ready) begin
        out_valid <= cls_valid;
      end
      if (pop) begin
        if (cls.last) begin
          bad_place_count    <= '0;
          bad_central_count  <= '0;
          bad_late_count     <= '0;
          good_late_count    <= '0;
          good_central_count <= '0;
          em_seen            <= 1'b0;
        end else begin
          bad_place_count    <= bad_place_next;
          bad_central_count  <= bad_central_next;
          bad_late_count     <= bad_late_next;
          good_late_count    <= good_late_next;
          good_central_count <= good_central_next;
          em_seen            <= em_seen_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      category     <= cls.category;
      peak_slot    <= cls.peak_slot;
      event_done   <= cls.last;
      event_pass   <= cls.last && (stage == REJ_NONE);
      reject_stage <= cls.last ? stage : REJ_NONE;
    end
  end

endmodule

// ===== rtl/calorimeter_pulse_timing_classifier.sv =====
// Pulse timing classifier for calorimeter trigger towers.
// Input channel (in_valid/in_ready): one tower per transaction, five ADC
// samples around the trigger slice, layer bit and last-of-event mark.
// Output channel (out_valid/out_ready): one result per tower, in order, with
// category, peak slot and, on the closing tower, the event verdict.
// Config channel (cfg_valid/cfg_ready): cfg_index selects the register,
// cfg_data carries the value; always ready, unknown indexes are dropped.
// An accepted tower passes the input stage, the queue and the output register
// in that order. Throughput: one tower per cycle while out_ready does not
// stall the pipe, with the classify stage and the counter update never holding it.
// The queue of FifoDepth entries lets the front keep accepting while the
// receiver stalls; in_ready drops only once the queue and input stage fill.
// Reset clears all per-event counters, empties the pipe and restores the
// default register values.
module calorimeter_pulse_timing_classifier import cpt_pkg::*; #(
  parameter int FifoDepth = FIFO_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ADC_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [ADC_W-1:0]     sample_0,
  input  logic [ADC_W-1:0]     sample_1,
  input  logic [ADC_W-1:0]     sample_2,
  input  logic [ADC_W-1:0]     sample_3,
  input  logic [ADC_W-1:0]     sample_4,
  input  logic                 is_hadronic,
  input  logic                 last_of_event,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [2:0]           category,
  output logic [SLOT_W-1:0]    peak_slot,
  output logic                 event_done,
  output logic                 event_pass,
  output logic [2:0]           reject_stage
);

  logic [ADC_W-1:0] threshold;
  limits_t          limits;

  logic cls_valid, cls_ready;
  cls_t cls;
  logic q_valid, q_ready;
  cls_t q_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold               <= THRESHOLD_RST;
      limits.max_bad_peak     <= MAX_BAD_PEAK_RST;
      limits.max_bad_central  <= MAX_BAD_CENTRAL_RST;
      limits.max_bad_late     <= MAX_BAD_LATE_RST;
      limits.min_good_late    <= MIN_GOOD_LATE_RST;
      limits.max_good_central <= MAX_GOOD_CENTRAL_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_THRESHOLD:        threshold <= cfg_data;
        CFG_MAX_BAD_PEAK:     limits.max_bad_peak <= cfg_data[CNT_W-1:0];
        CFG_MAX_BAD_CENTRAL:  limits.max_bad_central <= cfg_data[CNT_W-1:0];
        CFG_MAX_BAD_LATE:     limits.max_bad_late <= cfg_data[CNT_W-1:0];
        CFG_MIN_GOOD_LATE:    limits.min_good_late <= cfg_data[CNT_W-1:0];
        CFG_MAX_GOOD_CENTRAL: limits.max_good_central <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  cpt_front u_front (
    .clk           (clk),
    .rst           (rst),
    .threshold     (threshold),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .sample_0      (sample_0),
    .sample_1      (sample_1),
    .sample_2      (sample_2),
    .sample_3      (sample_3),
    .sample_4      (sample_4),
    .is_hadronic   (is_hadronic),
    .last_of_event (last_of_event),
    .cls_valid     (cls_valid),
    .cls_ready     (cls_ready),
    .cls           (cls)
  );

  cpt_queue #(
    .Depth (FifoDepth)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (cls_valid),
    .wr_ready (cls_ready),
    .wr_data  (cls),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_data  (q_data)
  );

  cpt_back u_back (
    .clk          (clk),
    .rst          (rst),
    .limits       (limits),
    .cls_valid    (q_valid),
    .cls_ready    (q_ready),
    .cls          (q_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .category     (category),
    .peak_slot    (peak_slot),
    .event_done   (event_done),
    .event_pass   (event_pass),
    .reject_stage (reject_stage)
  );

endmodule

// ===== rtl/cpt_checker.sv =====
module cpt_checker import cpt_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              out_valid,
  input logic              out_ready,
  input logic [2:0]        category,
  input logic [SLOT_W-1:0] peak_slot,
  input logic              event_done,
  input logic              event_pass,
  input logic [2:0]        reject_stage
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(category) &&
      $stable(peak_slot) && $stable(event_done) && $stable(reject_stage))
    else $error("stalled result changed");

  a_open_event: assert property (@(posedge clk) disable iff (rst)
    out_valid && !event_done |-> !event_pass && reject_stage == REJ_NONE)
    else $error("verdict on a tower that does not close the event");

  a_pass_match: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_done |-> event_pass == (reject_stage == REJ_NONE))
    else $error("pass flag disagrees with reject stage");

endmodule

bind calorimeter_pulse_timing_classifier cpt_checker u_cpt_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .category     (category),
  .peak_slot    (peak_slot),
  .event_done   (event_done),
  .event_pass   (event_pass),
  .reject_stage (reject_stage)
);
